// ===== src/timed_phase_sequencer_macros.svh =====
// Assertion macros shared by the sequencer RTL.
`ifndef TIMED_PHASE_SEQUENCER_MACROS_SVH
`define TIMED_PHASE_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TPS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequencer assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define TPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequencer assertion failed");

`endif

// ===== src/tps_pkg.sv =====
// Package with the codes, types and constants of the phase sequencer.
`timescale 1ns / 1ps
`default_nettype none
package tps_pkg;

   // Phase codes.
   localparam logic [2:0] PH_ACOLYTE = 3'd0;
   localparam logic [2:0] PH_GLYPH   = 3'd1;
   localparam logic [2:0] PH_ELDER   = 3'd2;
   localparam logic [2:0] PH_CTHULHU = 3'd3;
   localparam logic [2:0] PH_SEANCE  = 3'd4;

   // Command codes; codes six and seven are unused and change nothing.
   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_NEXT    = 3'd1;
   localparam logic [2:0] OP_ROLE    = 3'd2;
   localparam logic [2:0] OP_SEANCE  = 3'd3;
   localparam logic [2:0] OP_AUTO    = 3'd4;
   localparam logic [2:0] OP_MANUAL  = 3'd5;

   localparam int unsigned TIME_W = 32;
   localparam logic [TIME_W-1:0] LENGTH_RESET = 32'd10000;
   localparam logic [2:0] SLOTS_PER_PHASE = 3'd3;
   localparam logic [1:0] SLOT_MAX = 2'd3;

   // Bit count of the slot compare pass: elapsed time against up to three slot lengths.
   localparam int unsigned CMP_BITS = TIME_W + 2;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_BUSY,
      TOP_FINISH
   } top_state_type;

   typedef enum logic [1:0] {
      SER_IDLE,
      SER_SPLIT,
      SER_MEASURE
   } ser_state_type;

   // Status handed from the serial unit to the control logic.
   typedef struct packed {
      logic       done;
      logic       ge_len;
      logic       restart;
      logic [1:0] want;
   } ser_result_type;

endpackage
`default_nettype wire

// ===== src/tps_req_if.sv =====
// Command channel interface: valid, ready and the command word.
`timescale 1ns / 1ps
`default_nettype none
interface tps_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [31:0] now_ms;
   logic [1:0]  role_sel;

   modport source (output valid, output opcode, output now_ms, output role_sel,
                   input ready);
   modport sink (input valid, input opcode, input now_ms, input role_sel,
                 output ready);
endinterface
`default_nettype wire

// ===== src/tps_rsp_if.sv =====
// Status channel interface: valid, ready and the status word.
`timescale 1ns / 1ps
`default_nettype none
interface tps_rsp_if;
   logic        valid;
   logic        ready;
   logic        changed;
   logic [2:0]  phase_now;
   logic [1:0]  role_now;
   logic        in_seance;
   logic        auto_mode;
   logic [1:0]  slot_now;
   logic [31:0] remaining_ms;

   modport source (output valid, output changed, output phase_now, output role_now,
                   output in_seance, output auto_mode, output slot_now,
                   output remaining_ms, input ready);
   modport sink (input valid, input changed, input phase_now, input role_now,
                 input in_seance, input auto_mode, input slot_now,
                 input remaining_ms, output ready);
endinterface
`default_nettype wire

// ===== src/timed_phase_sequencer.sv =====
// Top level of the phase sequencer: command intake, phase state and status word.
// A command word is worked through in two bit-serial passes: first elapsed time and slot
// length, then the slot compares; the status word is posted once the status register is free.
// The next command word is accepted only after the status word of the last one is posted.
// A waiting status word does not block the next command word from being accepted.
// Reset (synchronous, active high) selects the acolyte phase, slot 0, start time 0,
// automatic mode and a phase length of 10000 ms.
`timescale 1ns / 1ps
`default_nettype none
module timed_phase_sequencer (
   input  wire logic                       clock,
   input  wire logic                       reset,
   tps_req_if.sink                         req_chan,
   tps_rsp_if.source                       rsp_chan,
   input  wire logic                       csr_wr_en,
   input  wire logic [tps_pkg::TIME_W-1:0] csr_wr_data
);

   tps_pkg::top_state_type state_ff, state_in;

   logic [tps_pkg::TIME_W-1:0] length_ff;
   logic [2:0]                 op_ff;
   logic [tps_pkg::TIME_W-1:0] now_ff;
   logic [1:0]                 role_ff;

   logic [2:0]                 phase_ff, phase_in;
   logic [1:0]                 slot_ff, slot_in;
   logic [tps_pkg::TIME_W-1:0] start_ff, start_in;
   logic                       auto_ff, auto_in;
   logic                       changed_in;

   logic                       rsp_valid_ff;
   logic                       rsp_changed_ff;
   logic [2:0]                 rsp_phase_ff;
   logic [1:0]                 rsp_role_ff;
   logic                       rsp_seance_ff;
   logic                       rsp_auto_ff;
   logic [1:0]                 rsp_slot_ff;
   logic [tps_pkg::TIME_W-1:0] rsp_remaining_ff;

   logic                       accept;
   logic                       load_rsp;
   logic                       ge_rem;
   logic [2:0]                 phase_next;
   logic                       slotted;
   tps_pkg::ser_result_type    ser_result;
   logic [tps_pkg::TIME_W-1:0] ser_remaining;

   assign accept = req_chan.valid & req_chan.ready;

   tps_serial_unit u_serial (
      .clock        (clock),
      .reset        (reset),
      .start        (accept),
      .now_ms       (now_ff),
      .start_ms     (start_ff),
      .length_ms    (length_ff),
      .opcode       (op_ff),
      .auto_flag    (auto_ff),
      .result       (ser_result),
      .remaining_ms (ser_remaining)
   );

   // Control state machine: take a word, wait for the serial unit, post the status.
   always_comb begin
      state_in = state_ff;
      req_chan.ready = 1'b0;
      load_rsp = 1'b0;
      case (state_ff)
         tps_pkg::TOP_IDLE: begin
            req_chan.ready = !reset;
            if (req_chan.valid) begin
               state_in = tps_pkg::TOP_BUSY;
            end
         end
         tps_pkg::TOP_BUSY: begin
            if (ser_result.done) begin
               state_in = tps_pkg::TOP_FINISH;
            end
         end
         tps_pkg::TOP_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = tps_pkg::TOP_IDLE;
            end
         end
         default: begin
            state_in = tps_pkg::TOP_IDLE;
         end
      endcase
   end

   assign phase_next = (phase_ff == tps_pkg::PH_SEANCE) ? tps_pkg::PH_ACOLYTE
                                                         : phase_ff + 3'd1;
   assign slotted = (phase_ff == tps_pkg::PH_ACOLYTE) || (phase_ff == tps_pkg::PH_SEANCE);

   // Phase state update for the finished command.
   always_comb begin
      phase_in = phase_ff;
      slot_in = slot_ff;
      start_in = start_ff;
      auto_in = auto_ff;
      changed_in = 1'b0;
      case (op_ff)
         tps_pkg::OP_TICK: begin
            if (auto_ff) begin
               if (ser_result.ge_len) begin
                  phase_in = phase_next;
                  slot_in = 2'd0;
                  start_in = now_ff;
                  changed_in = 1'b1;
               end else if (slotted && (ser_result.want != slot_ff)) begin
                  slot_in = ser_result.want;
                  changed_in = 1'b1;
               end
            end
         end
         tps_pkg::OP_NEXT: begin
            phase_in = phase_next;
            slot_in = 2'd0;
            start_in = now_ff;
         end
         tps_pkg::OP_ROLE: begin
            phase_in = {1'b0, role_ff};
            slot_in = 2'd0;
            start_in = now_ff;
            auto_in = 1'b0;
         end
         tps_pkg::OP_SEANCE: begin
            phase_in = tps_pkg::PH_SEANCE;
            slot_in = 2'd0;
            start_in = now_ff;
            auto_in = 1'b0;
         end
         tps_pkg::OP_AUTO: begin
            slot_in = 2'd0;
            start_in = now_ff;
            auto_in = 1'b1;
         end
         tps_pkg::OP_MANUAL: begin
            auto_in = 1'b0;
         end
         default: begin
            auto_in = auto_ff;
         end
      endcase
   end

   // After a restart the elapsed time is zero, so the phase is over only at length zero.
   assign ge_rem = ser_result.restart ? (length_ff == '0) : ser_result.ge_len;

   // Control registers and phase state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tps_pkg::TOP_IDLE;
         length_ff <= tps_pkg::LENGTH_RESET;
         phase_ff <= tps_pkg::PH_ACOLYTE;
         slot_ff <= 2'd0;
         start_ff <= '0;
         auto_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            length_ff <= csr_wr_data;
         end
         if (load_rsp) begin
            phase_ff <= phase_in;
            slot_ff <= slot_in;
            start_ff <= start_in;
            auto_ff <= auto_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Command word capture and status word register.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_chan.opcode;
         now_ff <= req_chan.now_ms;
         role_ff <= req_chan.role_sel;
      end
      if (load_rsp) begin
         rsp_changed_ff <= changed_in;
         rsp_phase_ff <= phase_in;
         rsp_role_ff <= ((phase_in >= tps_pkg::PH_GLYPH) && (phase_in <= tps_pkg::PH_CTHULHU))
                        ? phase_in[1:0] : 2'd0;
         rsp_seance_ff <= (phase_in == tps_pkg::PH_SEANCE);
         rsp_auto_ff <= auto_in;
         rsp_slot_ff <= slot_in;
         rsp_remaining_ff <= (auto_in && !ge_rem) ? ser_remaining : '0;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.changed = rsp_changed_ff;
   assign rsp_chan.phase_now = rsp_phase_ff;
   assign rsp_chan.role_now = rsp_role_ff;
   assign rsp_chan.in_seance = rsp_seance_ff;
   assign rsp_chan.auto_mode = rsp_auto_ff;
   assign rsp_chan.slot_now = rsp_slot_ff;
   assign rsp_chan.remaining_ms = rsp_remaining_ff;

`include "timed_phase_sequencer_macros.svh"

   // The serial unit finishes only while a command is in flight.
   `TPS_ASSERT_IMPLIES(a_done_busy, clock, reset, ser_result.done, state_ff == tps_pkg::TOP_BUSY)
   // The phase code never leaves the five phases.
   `TPS_ASSERT_IMPLIES(a_phase_range, clock, reset, 1'b1, phase_ff <= tps_pkg::PH_SEANCE)
   // A nonzero slot is only held in a slotted phase.
   `TPS_ASSERT_IMPLIES(a_slot_phase, clock, reset, slot_ff != 2'd0, slotted)
   // Manual mode always reports zero time left.
   `TPS_ASSERT_IMPLIES(a_manual_zero, clock, reset, rsp_valid_ff && !rsp_auto_ff, rsp_remaining_ff == '0)
   // A status word is posted in the cycle after the finish state allows it.
   `TPS_ASSERT_NEXT(a_post, clock, reset, load_rsp, rsp_valid_ff && state_ff == tps_pkg::TOP_IDLE)

endmodule
`default_nettype wire

// ===== src/tps_serial_unit.sv =====
// Bit-serial time unit: elapsed time, slot length, slot index and time left.
`timescale 1ns / 1ps
`default_nettype none
module tps_serial_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [tps_pkg::TIME_W-1:0]    now_ms,
   input  wire logic [tps_pkg::TIME_W-1:0]    start_ms,
   input  wire logic [tps_pkg::TIME_W-1:0]    length_ms,
   input  wire logic [2:0]                    opcode,
   input  wire logic                          auto_flag,
   output tps_pkg::ser_result_type            result,
   output logic [tps_pkg::TIME_W-1:0]         remaining_ms
);

   localparam int unsigned CNT_W = $clog2(tps_pkg::CMP_BITS);
   localparam logic [CNT_W-1:0] SPLIT_LAST = CNT_W'(tps_pkg::TIME_W - 1);
   localparam logic [CNT_W-1:0] MEASURE_LAST = CNT_W'(tps_pkg::CMP_BITS - 1);

   tps_pkg::ser_state_type state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [tps_pkg::TIME_W-1:0] elapsed_ff, elapsed_in;
   logic [tps_pkg::TIME_W-1:0] quot_ff, quot_in;
   logic [tps_pkg::TIME_W-1:0] rem_ff, rem_in;
   logic [1:0]                div_ff, div_in;
   logic                      eb_ff, eb_in;
   logic                      bl_ff, bl_in;
   logic [2:0]                bs_ff, bs_in;
   logic                      c3_ff, c3_in;
   logic                      sprev_ff, sprev_in;
   logic                      br_ff, br_in;
   logic                      ge_len_ff, ge_len_in;
   logic                      restart_ff, restart_in;
   logic [1:0]                want_ff, want_in;
   logic                      done_ff, done_in;

   logic [4:0] idx;
   logic       in_word;
   logic       e_bit, l_bit, d_bit, q_bit;
   logic [2:0] r2, r2_sub;
   logic       s_bit, t_bit, u_bit, x_bit, slot_zero;
   logic       restart_now;

   // Borrow out of one bit of a serial subtraction a - b.
   function automatic logic borrow_of(input logic a, input logic b, input logic bin);
      return (~a & b) | (~(a ^ b) & bin);
   endfunction

   assign idx = cnt_ff[4:0];
   assign in_word = (cnt_ff < CNT_W'(tps_pkg::TIME_W));
   assign slot_zero = (quot_ff == '0);

   // Bits for the first pass: elapsed time LSB first, slot length MSB first.
   assign e_bit = now_ms[idx] ^ start_ms[idx] ^ eb_ff;
   assign l_bit = length_ms[idx];
   assign d_bit = length_ms[~idx];
   assign r2 = {div_ff, d_bit};
   assign r2_sub = r2 - tps_pkg::SLOTS_PER_PHASE;
   assign q_bit = (r2 >= tps_pkg::SLOTS_PER_PHASE);

   // Bits for the second pass: slot length s, 2s, 3s and the time-left difference.
   assign s_bit = in_word ? (slot_zero ? (idx == 5'd0) : quot_ff[idx]) : 1'b0;
   assign t_bit = sprev_ff;
   assign u_bit = s_bit ^ t_bit ^ c3_ff;
   assign x_bit = in_word ? (elapsed_ff[idx] & ~restart_ff) : 1'b0;

   // Which commands restart the phase timer, given the length compare.
   always_comb begin
      case (opcode)
         tps_pkg::OP_TICK: begin
            restart_now = auto_flag & ~borrow_of(e_bit, l_bit, bl_ff);
         end
         tps_pkg::OP_NEXT, tps_pkg::OP_ROLE, tps_pkg::OP_SEANCE, tps_pkg::OP_AUTO: begin
            restart_now = 1'b1;
         end
         default: begin
            restart_now = 1'b0;
         end
      endcase
   end

   // Sequencer for the two serial passes.
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      elapsed_in = elapsed_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      eb_in = eb_ff;
      bl_in = bl_ff;
      bs_in = bs_ff;
      c3_in = c3_ff;
      sprev_in = sprev_ff;
      br_in = br_ff;
      ge_len_in = ge_len_ff;
      restart_in = restart_ff;
      want_in = want_ff;
      done_in = 1'b0;
      case (state_ff)
         tps_pkg::SER_IDLE: begin
            if (start) begin
               state_in = tps_pkg::SER_SPLIT;
               cnt_in = '0;
               div_in = '0;
               eb_in = 1'b0;
               bl_in = 1'b0;
               bs_in = '0;
               c3_in = 1'b0;
               sprev_in = 1'b0;
               br_in = 1'b0;
            end
         end
         tps_pkg::SER_SPLIT: begin
            elapsed_in = {e_bit, elapsed_ff[tps_pkg::TIME_W-1:1]};
            eb_in = borrow_of(now_ms[idx], start_ms[idx], eb_ff);
            bl_in = borrow_of(e_bit, l_bit, bl_ff);
            quot_in = {quot_ff[tps_pkg::TIME_W-2:0], q_bit};
            div_in = q_bit ? r2_sub[1:0] : r2[1:0];
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == SPLIT_LAST) begin
               state_in = tps_pkg::SER_MEASURE;
               cnt_in = '0;
               ge_len_in = ~borrow_of(e_bit, l_bit, bl_ff);
               restart_in = restart_now;
            end
         end
         tps_pkg::SER_MEASURE: begin
            bs_in[0] = borrow_of(x_bit | 1'b0, s_bit, bs_ff[0]);
            bs_in[1] = borrow_of(x_bit | 1'b0, t_bit, bs_ff[1]);
            bs_in[2] = borrow_of(x_bit | 1'b0, u_bit, bs_ff[2]);
            c3_in = (s_bit & t_bit) | (s_bit & c3_ff) | (t_bit & c3_ff);
            sprev_in = s_bit;
            if (in_word) begin
               rem_in = {l_bit ^ x_bit ^ br_ff, rem_ff[tps_pkg::TIME_W-1:1]};
               br_in = borrow_of(l_bit, x_bit, br_ff);
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == MEASURE_LAST) begin
               state_in = tps_pkg::SER_IDLE;
               done_in = 1'b1;
               if (~bs_in[2]) begin
                  want_in = tps_pkg::SLOT_MAX;
               end else if (~bs_in[1]) begin
                  want_in = 2'd2;
               end else if (~bs_in[0]) begin
                  want_in = 2'd1;
               end else begin
                  want_in = 2'd0;
               end
            end
         end
         default: begin
            state_in = tps_pkg::SER_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tps_pkg::SER_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
   end

   // Shift registers and serial carries.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      elapsed_ff <= elapsed_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      eb_ff <= eb_in;
      bl_ff <= bl_in;
      bs_ff <= bs_in;
      c3_ff <= c3_in;
      sprev_ff <= sprev_in;
      br_ff <= br_in;
      ge_len_ff <= ge_len_in;
      restart_ff <= restart_in;
      want_ff <= want_in;
   end

   assign result.done = done_ff;
   assign result.ge_len = ge_len_ff;
   assign result.restart = restart_ff;
   assign result.want = want_ff;
   assign remaining_ms = rem_ff;

endmodule
`default_nettype wire

// ===== tb/sv/timed_phase_sequencer_test.sv =====
// Self-checking testbench for the timed phase sequencer: directed table, then random commands.
`timescale 1ns / 1ps
module timed_phase_sequencer_test;

   // Opcodes the block leaves unused, and the role codes of the role field.
   localparam logic [2:0] OP_SPARE_6   = 3'd6;
   localparam logic [2:0] OP_SPARE_7   = 3'd7;
   localparam logic [1:0] ROLE_ACOLYTE = 2'd0;
   localparam logic [1:0] ROLE_GLYPH   = 2'd1;
   localparam logic [1:0] ROLE_ELDER   = 2'd2;
   localparam logic [1:0] ROLE_CTHULHU = 2'd3;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 12;
   localparam int SEGMENTS       = 9;
   localparam int SEGMENT_WORDS  = 128;
   localparam int RANDOM_SEGMENT = 6;
   localparam int MAX_GAP        = 80;
   localparam int DRAIN_CYCLES   = 80;
   localparam int TIMEOUT_NS     = 10_000_000;
   localparam int SCRIPT_ROWS    = 27;

   typedef struct packed {
      logic        changed;
      logic [2:0]  phase_now;
      logic [1:0]  role_now;
      logic        in_seance;
      logic        auto_mode;
      logic [1:0]  slot_now;
      logic [31:0] remaining_ms;
   } status_word_type;

   // One directed step: either a phase length write or a command word.
   typedef struct packed {
      logic            is_write;
      logic [2:0]      opcode;
      logic [31:0]     value;
      logic [1:0]      role_sel;
      logic            typed;
      status_word_type want;
   } script_row_type;

   // Directed commands, starting from reset with a phase length of 10000 ms.
   script_row_type script [SCRIPT_ROWS] = '{
      '{1'b0, tps_pkg::OP_TICK, 32'd0, ROLE_ACOLYTE, 1'b1,
        '{1'b0, tps_pkg::PH_ACOLYTE, ROLE_ACOLYTE, 1'b0, 1'b1, 2'd0, 32'd10000}},
      '{1'b0, tps_pkg::OP_TICK, 32'd3333, ROLE_ACOLYTE, 1'b1,
        '{1'b1, tps_pkg::PH_ACOLYTE, ROLE_ACOLYTE, 1'b0, 1'b1, 2'd1, 32'd6667}},
      '{1'b0, tps_pkg::OP_TICK, 32'd9999, ROLE_ACOLYTE, 1'b0, '0},
      '{1'b0, tps_pkg::OP_TICK, 32'd10000, ROLE_ACOLYTE, 1'b1,
        '{1'b1, tps_pkg::PH_GLYPH, ROLE_GLYPH, 1'b0, 1'b1, 2'd0, 32'd10000}},
      '{1'b0, tps_pkg::OP_NEXT, 32'd20000, ROLE_ACOLYTE, 1'b1,
        '{1'b0, tps_pkg::PH_ELDER, ROLE_ELDER, 1'b0, 1'b1, 2'd0, 32'd10000}},
      '{1'b0, tps_pkg::OP_NEXT, 32'd20000, ROLE_ACOLYTE, 1'b1,
        '{1'b0, tps_pkg::PH_CTHULHU, ROLE_CTHULHU, 1'b0, 1'b1, 2'd0, 32'd10000}},
      '{1'b0, tps_pkg::OP_NEXT, 32'd0, ROLE_ACOLYTE, 1'b1,
        '{1'b0, tps_pkg::PH_SEANCE, ROLE_ACOLYTE, 1'b1, 1'b1, 2'd0, 32'd10000}},
      '{1'b0, tps_pkg::OP_NEXT, 32'hFFFF_FFFF, ROLE_ACOLYTE, 1'b1,
        '{1'b0, tps_pkg::PH_ACOLYTE, ROLE_ACOLYTE, 1'b0, 1'b1, 2'd0, 32'd10000}},
      '{1'b0, tps_pkg::OP_TICK, 32'd3332, ROLE_ACOLYTE, 1'b0, '0},
      '{1'b0, tps_pkg::OP_ROLE, 32'd100, ROLE_CTHULHU, 1'b1,
        '{1'b0, tps_pkg::PH_CTHULHU, ROLE_CTHULHU, 1'b0, 1'b0, 2'd0, 32'd0}},
      '{1'b0, tps_pkg::OP_TICK, 32'd50000, ROLE_ACOLYTE, 1'b1,
        '{1'b0, tps_pkg::PH_CTHULHU, ROLE_CTHULHU, 1'b0, 1'b0, 2'd0, 32'd0}},
      '{1'b0, tps_pkg::OP_ROLE, 32'd0, ROLE_GLYPH, 1'b0, '0},
      '{1'b0, tps_pkg::OP_SEANCE, 32'd7, ROLE_ACOLYTE, 1'b1,
        '{1'b0, tps_pkg::PH_SEANCE, ROLE_ACOLYTE, 1'b1, 1'b0, 2'd0, 32'd0}},
      '{1'b0, tps_pkg::OP_AUTO, 32'd1000, ROLE_ACOLYTE, 1'b1,
        '{1'b0, tps_pkg::PH_SEANCE, ROLE_ACOLYTE, 1'b1, 1'b1, 2'd0, 32'd10000}},
      '{1'b0, tps_pkg::OP_TICK, 32'd7666, ROLE_ACOLYTE, 1'b0, '0},
      '{1'b0, tps_pkg::OP_MANUAL, 32'd8000, ROLE_ACOLYTE, 1'b0, '0},
      '{1'b0, OP_SPARE_6, 32'hFFFF_FFFF, ROLE_CTHULHU, 1'b0, '0},
      '{1'b0, OP_SPARE_7, 32'd0, ROLE_ACOLYTE, 1'b0, '0},
      '{1'b0, tps_pkg::OP_AUTO, 32'd0, ROLE_ACOLYTE, 1'b0, '0},
      '{1'b1, tps_pkg::OP_TICK, 32'd5, ROLE_ACOLYTE, 1'b0, '0},
      '{1'b0, tps_pkg::OP_TICK, 32'd4, ROLE_ACOLYTE, 1'b0, '0},
      '{1'b1, tps_pkg::OP_TICK, 32'd0, ROLE_ACOLYTE, 1'b0, '0},
      '{1'b0, tps_pkg::OP_TICK, 32'd0, ROLE_ACOLYTE, 1'b1,
        '{1'b1, tps_pkg::PH_ACOLYTE, ROLE_ACOLYTE, 1'b0, 1'b1, 2'd0, 32'd0}},
      '{1'b0, tps_pkg::OP_TICK, 32'd0, ROLE_ACOLYTE, 1'b0, '0},
      '{1'b1, tps_pkg::OP_TICK, 32'hFFFF_FFFF, ROLE_ACOLYTE, 1'b0, '0},
      '{1'b0, tps_pkg::OP_TICK, 32'hFFFF_FFFF, ROLE_ACOLYTE, 1'b0, '0},
      '{1'b0, tps_pkg::OP_ROLE, 32'd0, ROLE_ELDER, 1'b0, '0}
   };

   // Phase lengths of the random segments; one segment draws its length at random.
   logic [31:0] segment_length [SEGMENTS] = '{
      32'd3, 32'd100, 32'hFFFF_FFFF, 32'd5, 32'd10000, 32'd0, 32'd0, 32'd2, 32'd1
   };
   int sender_idle_plan [3]   = '{31, 56, 0};
   int receiver_idle_plan [3] = '{56, 31, 0};

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_wr_en;
   logic [tps_pkg::TIME_W-1:0] csr_wr_data;

   tps_req_if req_bus ();
   tps_rsp_if rsp_bus ();

   timed_phase_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // Sequencer state as the testbench sees it.
   logic [2:0]  show_phase;
   logic [1:0]  show_slot;
   logic [31:0] show_start;
   logic        show_auto;
   logic [31:0] show_length;

   status_word_type expected_status [$];
   int fail_count        = 0;
   int sender_idle_pct   = 31;
   int receiver_idle_pct = 56;

   function automatic logic [2:0] following_phase(input logic [2:0] phase);
      return (phase < tps_pkg::PH_SEANCE) ? phase + 3'd1 : tps_pkg::PH_ACOLYTE;
   endfunction

   // Applies one command to the show state and returns the status word it answers with.
   function automatic status_word_type advance_show(input logic [2:0] opcode,
                                                    input logic [31:0] now_ms,
                                                    input logic [1:0] role_sel);
      status_word_type word;
      logic [31:0]     elapsed;
      logic [31:0]     slot_len;
      logic [31:0]     wanted;
      word = '0;
      case (opcode)
         tps_pkg::OP_TICK: begin
            if (show_auto) begin
               elapsed = now_ms - show_start;
               if (elapsed >= show_length) begin
                  show_phase   = following_phase(show_phase);
                  show_slot    = 2'd0;
                  show_start   = now_ms;
                  word.changed = 1'b1;
               end else if (show_phase == tps_pkg::PH_ACOLYTE ||
                            show_phase == tps_pkg::PH_SEANCE) begin
                  // A slot is a third of the phase, never shorter than one ms.
                  slot_len = show_length / tps_pkg::SLOTS_PER_PHASE;
                  if (slot_len == 32'd0) begin
                     slot_len = 32'd1;
                  end
                  wanted = elapsed / slot_len;
                  if (wanted > tps_pkg::SLOT_MAX) begin
                     wanted = tps_pkg::SLOT_MAX;
                  end
                  if (wanted[1:0] != show_slot) begin
                     show_slot    = wanted[1:0];
                     word.changed = 1'b1;
                  end
               end
            end
         end
         tps_pkg::OP_NEXT: begin
            show_phase = following_phase(show_phase);
            show_slot  = 2'd0;
            show_start = now_ms;
         end
         tps_pkg::OP_ROLE: begin
            show_phase = {1'b0, role_sel};
            show_slot  = 2'd0;
            show_start = now_ms;
            show_auto  = 1'b0;
         end
         tps_pkg::OP_SEANCE: begin
            show_phase = tps_pkg::PH_SEANCE;
            show_slot  = 2'd0;
            show_start = now_ms;
            show_auto  = 1'b0;
         end
         tps_pkg::OP_AUTO: begin
            show_auto  = 1'b1;
            show_slot  = 2'd0;
            show_start = now_ms;
         end
         tps_pkg::OP_MANUAL: begin
            show_auto = 1'b0;
         end
         default: begin
         end
      endcase
      word.phase_now = show_phase;
      word.role_now  = (show_phase >= tps_pkg::PH_GLYPH && show_phase <= tps_pkg::PH_CTHULHU) ?
                       show_phase[1:0] : ROLE_ACOLYTE;
      word.in_seance = (show_phase == tps_pkg::PH_SEANCE);
      word.auto_mode = show_auto;
      word.slot_now  = show_slot;
      if (show_auto) begin
         elapsed = now_ms - show_start;
         word.remaining_ms = (elapsed >= show_length) ? 32'd0 : show_length - elapsed;
      end
      return word;
   endfunction

   function automatic void report_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic wait_idle();
      while (expected_status.size() != 0) @(posedge clock);
   endtask

   // Sends one command word, with an optional gap first, and records its expected status.
   task automatic send_command(input logic [2:0] opcode, input logic [31:0] now_ms,
                               input logic [1:0] role_sel, input logic typed,
                               input status_word_type typed_word);
      status_word_type predicted;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.opcode   <= opcode;
      req_bus.now_ms   <= now_ms;
      req_bus.role_sel <= role_sel;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = advance_show(opcode, now_ms, role_sel);
      expected_status.push_back(typed ? typed_word : predicted);
   endtask

   // Writes the phase length once every status word has come back.
   task automatic write_length(input logic [31:0] length);
      req_bus.valid <= 1'b0;
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= length;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      show_length = length;
   endtask

   // Status channel: compare each accepted word with the oldest expectation.
   initial begin : status_monitor
      status_word_type seen;
      status_word_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            seen = {rsp_bus.changed, rsp_bus.phase_now, rsp_bus.role_now, rsp_bus.in_seance,
                    rsp_bus.auto_mode, rsp_bus.slot_now, rsp_bus.remaining_ms};
            if (expected_status.size() == 0) begin
               $error("status word arrived with no command outstanding");
               fail_count++;
            end else begin
               want = expected_status.pop_front();
               report_field("changed", want.changed, seen.changed);
               report_field("phase_now", want.phase_now, seen.phase_now);
               report_field("role_now", want.role_now, seen.role_now);
               report_field("in_seance", want.in_seance, seen.in_seance);
               report_field("auto_mode", want.auto_mode, seen.auto_mode);
               report_field("slot_now", want.slot_now, seen.slot_now);
               report_field("remaining_ms", want.remaining_ms, seen.remaining_ms);
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   initial begin : stimulus
      script_row_type row;
      logic [31:0]    show_clock;
      logic [31:0]    now_ms;
      logic [31:0]    length;
      logic [2:0]     opcode;
      logic [1:0]     role_sel;
      int             pick;
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.opcode   <= tps_pkg::OP_TICK;
      req_bus.now_ms   <= '0;
      req_bus.role_sel <= ROLE_ACOLYTE;
      show_phase  = tps_pkg::PH_ACOLYTE;
      show_slot   = 2'd0;
      show_start  = '0;
      show_auto   = 1'b1;
      show_length = tps_pkg::LENGTH_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         row = script[i];
         if (row.is_write) begin
            write_length(row.value);
         end else begin
            send_command(row.opcode, row.value, row.role_sel, row.typed, row.want);
         end
      end

      // Random segments, each with its own phase length; each run of three segments shares an idling pattern.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         sender_idle_pct   = sender_idle_plan[seg / 3];
         receiver_idle_pct = receiver_idle_plan[seg / 3];
         length = (seg == RANDOM_SEGMENT) ? $urandom : segment_length[seg];
         write_length(length);
         show_clock = $urandom;
         for (int n = 0; n < SEGMENT_WORDS; n++) begin
            pick     = $urandom_range(0, 99);
            role_sel = 2'($urandom_range(0, 3));
            if (pick < 8) begin
               // Noise: any opcode at any time stamp.
               opcode = 3'($urandom_range(0, 7));
               now_ms = $urandom;
            end else begin
               // Time moves forward in steps that suit the phase length, with
               // some stamps placed right at a phase end or a slot edge.
               if (pick < 14) begin
                  show_clock = show_start + show_length - 32'd1 + $urandom_range(0, 2);
               end else if (pick < 20) begin
                  show_clock = show_start + show_length / tps_pkg::SLOTS_PER_PHASE *
                               $urandom_range(1, 3) - $urandom_range(0, 1);
               end else begin
                  show_clock = show_clock +
                               $urandom_range(0, show_length / tps_pkg::SLOTS_PER_PHASE + 1);
               end
               now_ms = show_clock;
               pick   = $urandom_range(0, 99);
               if (pick < 62) begin
                  opcode = tps_pkg::OP_TICK;
               end else if (pick < 70) begin
                  opcode = tps_pkg::OP_NEXT;
               end else if (pick < 77) begin
                  opcode = tps_pkg::OP_ROLE;
               end else if (pick < 82) begin
                  opcode = tps_pkg::OP_SEANCE;
               end else if (pick < 91) begin
                  opcode = tps_pkg::OP_AUTO;
               end else if (pick < 97) begin
                  opcode = tps_pkg::OP_MANUAL;
               end else begin
                  opcode = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
               end
            end
            send_command(opcode, now_ms, role_sel, 1'b0, '0);
         end
      end

      req_bus.valid <= 1'b0;
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("== FAIL ==");
      $finish;
   end

endmodule
